// File: hw/rtl/ukt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukt_pkg
// Shared types, token kinds and keyword table for the keyword tokeniser.
// ----------------------------------------------------------------------------
package ukt_pkg;

   localparam int LineBitsDefault   = 16;
   localparam int ColumnBitsDefault = 16;
   localparam int LengthBitsDefault = 8;

   localparam int NumKeywords = 7;
   localparam int MaxKwLen    = 18;
   localparam int MaxTokens   = 4;

   // scan modes
   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_COMMENT = 4'd1;
   localparam logic [3:0] M_SLASH   = 4'd2;
   localparam logic [3:0] M_EQ      = 4'd3;
   localparam logic [3:0] M_BANG    = 4'd4;
   localparam logic [3:0] M_LT      = 4'd5;
   localparam logic [3:0] M_GT      = 4'd6;
   localparam logic [3:0] M_INT     = 4'd7;
   localparam logic [3:0] M_INTDOT  = 4'd8;
   localparam logic [3:0] M_FLOAT   = 4'd9;
   localparam logic [3:0] M_WORD    = 4'd10;

   // token kinds
   localparam logic [4:0] K_IDENT   = 5'd7;
   localparam logic [4:0] K_INT     = 5'd8;
   localparam logic [4:0] K_FLOAT   = 5'd9;
   localparam logic [4:0] K_PLUS    = 5'd10;
   localparam logic [4:0] K_MINUS   = 5'd11;
   localparam logic [4:0] K_STAR    = 5'd12;
   localparam logic [4:0] K_SLASH   = 5'd13;
   localparam logic [4:0] K_LPAREN  = 5'd14;
   localparam logic [4:0] K_RPAREN  = 5'd15;
   localparam logic [4:0] K_LBRACE  = 5'd16;
   localparam logic [4:0] K_RBRACE  = 5'd17;
   localparam logic [4:0] K_SEMI    = 5'd18;
   localparam logic [4:0] K_ASSIGN  = 5'd19;
   localparam logic [4:0] K_EQ      = 5'd20;
   localparam logic [4:0] K_NEQ     = 5'd21;
   localparam logic [4:0] K_LT      = 5'd22;
   localparam logic [4:0] K_LE      = 5'd23;
   localparam logic [4:0] K_GT      = 5'd24;
   localparam logic [4:0] K_GE      = 5'd25;
   localparam logic [4:0] K_UNKNOWN = 5'd26;
   localparam logic [4:0] K_EOF     = 5'd27;

   function automatic logic [4:0] kw_len(input logic [2:0] k);
      logic [4:0] r;
      unique case (k)
         3'd0, 3'd1:       r = 5'd9;
         3'd3, 3'd5:       r = 5'd18;
         default:          r = 5'd15;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] mid_byte(input logic [2:0] k, input logic [4:0] p);
      logic a7;
      a7 = 1'b0;
      unique case (k)
         3'd2:    a7 = (p == 5'd13);
         3'd3:    a7 = (p == 5'd10);
         3'd4:    a7 = (p == 5'd4);
         3'd5:    a7 = (p == 5'd10);
         default: a7 = 1'b0;
      endcase
      return a7 ? 8'hA7 : 8'hA6;
   endfunction

   // Keyword byte at a given position; 0 past the end of the keyword.
   function automatic logic [7:0] kw_byte(input logic [2:0] k, input logic [4:0] p);
      logic [7:0] tail;
      logic [7:0] r;
      tail = 8'h00;
      r    = 8'h00;
      unique case (k)
         3'd0: begin
            unique case (p)
               5'd2: tail = 8'hA7; 5'd5: tail = 8'hB0; 5'd8: tail = 8'hBF;
               default: tail = 8'h00;
            endcase
         end
         3'd1: begin
            unique case (p)
               5'd2: tail = 8'hAF; 5'd5: tail = 8'hA6; 5'd8: tail = 8'hBF;
               default: tail = 8'h00;
            endcase
         end
         3'd2: begin
            unique case (p)
               5'd2: tail = 8'hA8; 5'd5: tail = 8'hBE; 5'd8: tail = 8'hB9;
               5'd11: tail = 8'hB2; 5'd14: tail = 8'h87;
               default: tail = 8'h00;
            endcase
         end
         3'd3: begin
            unique case (p)
               5'd2: tail = 8'hAF; 5'd5: tail = 8'hA4; 5'd8: tail = 8'h95;
               5'd11: tail = 8'h8D; 5'd14: tail = 8'hB7; 5'd17: tail = 8'hA3;
               default: tail = 8'h00;
            endcase
         end
         3'd4: begin
            unique case (p)
               5'd2: tail = 8'hA6; 5'd5: tail = 8'h87; 5'd8: tail = 8'h96;
               5'd11: tail = 8'hBE; 5'd14: tail = 8'h93;
               default: tail = 8'h00;
            endcase
         end
         3'd5: begin
            unique case (p)
               5'd2: tail = 8'hB8; 5'd5: tail = 8'h82; 5'd8: tail = 8'h96;
               5'd11: tail = 8'h8D; 5'd14: tail = 8'hAF; 5'd17: tail = 8'hBE;
               default: tail = 8'h00;
            endcase
         end
         3'd6: begin
            unique case (p)
               5'd2: tail = 8'hA6; 5'd5: tail = 8'hB6; 5'd8: tail = 8'hAE;
               5'd11: tail = 8'hBF; 5'd14: tail = 8'h95;
               default: tail = 8'h00;
            endcase
         end
         default: tail = 8'h00;
      endcase
      // Every keyword character is E0 A6/A7 xx; the middle byte is A7 only
      // where the tail is a vowel sign or virama from that block.
      if ({3'd0, p} < 8'(kw_len(k))) begin
         unique case (p)
            5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15:  r = 8'hE0;
            5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16: r = mid_byte(k, p);
            default:                               r = tail;
         endcase
      end
      return r;
   endfunction

   typedef struct packed {
      logic [4:0] kind;
      logic       err;
      logic       at_cursor;  // take line/column from the cursor, else held
      logic       dot_col;    // column from the held dot
      logic [1:0] len_sel;    // 0 held count, 1 one, 2 two, 3 zero
   } tok_desc_type;

endpackage : ukt_pkg
`default_nettype wire

// File: hw/rtl/ukt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukt_front
// Scanner: takes one byte per beat, updates mode and counters, and produces
// up to four fully formed tokens for the queue.
// ----------------------------------------------------------------------------
module ukt_front
   import ukt_pkg::*;
#(
   parameter int LINE_BITS   = LineBitsDefault,
   parameter int COLUMN_BITS = ColumnBitsDefault,
   parameter int LENGTH_BITS = LengthBitsDefault,
   parameter int TOK_BITS    = 5 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            source_byte,
   input  wire logic                  byte_present,
   input  wire logic                  end_of_source,
   output logic [2:0]                 tok_count,
   output logic [MaxTokens-1:0][TOK_BITS-1:0] tok_data
);

   localparam logic [LINE_BITS-1:0]   LineMax = '1;
   localparam logic [COLUMN_BITS-1:0] ColMax  = '1;
   localparam logic [LENGTH_BITS-1:0] LenMax  = '1;

   logic [3:0]             mode_ff, mode_in;
   logic [LINE_BITS-1:0]   tline_ff, tline_in, line_ff, line_in;
   logic [COLUMN_BITS-1:0] tcol_ff, tcol_in, col_ff, col_in, dot_ff, dot_in;
   logic [LENGTH_BITS-1:0] cnt_ff, cnt_in;
   logic [NumKeywords-1:0] kw_ff, kw_in;

   tok_desc_type desc [MaxTokens];
   logic [1:0]   n;

   logic [7:0] b;
   logic       digit, wstart, redo, flush, idle_go, is_nl;
   logic [LENGTH_BITS-1:0] cnt_inc;
   logic [4:0] kw_pos;
   logic [4:0] word_kind;

   assign b       = source_byte;
   assign digit   = (b >= 8'h30) && (b <= 8'h39);
   assign wstart  = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
                    || (b == 8'h5F) || b[7];
   assign is_nl   = (b == 8'h0A);
   assign cnt_inc = (cnt_ff == LenMax) ? cnt_ff : cnt_ff + 1'b1;
   assign kw_pos  = (cnt_ff > LENGTH_BITS'(31)) ? 5'd31 : 5'(cnt_ff);

   always_comb begin
      word_kind = K_IDENT;
      for (int k = NumKeywords - 1; k >= 0; k--) begin
         if (kw_ff[k] && (cnt_ff == LENGTH_BITS'(kw_len(3'(k)))))
            word_kind = 5'(k);
      end
   end

   // Descriptor of the token held in the current mode.
   function automatic tok_desc_type held(input logic [4:0] kind, input logic err);
      tok_desc_type d;
      d = '{kind: kind, err: err, at_cursor: 1'b0, dot_col: 1'b0, len_sel: 2'd0};
      return d;
   endfunction

   always_comb begin
      logic [3:0] m;
      logic       fl;
      m         = mode_ff;
      mode_in   = mode_ff;
      tline_in  = tline_ff;
      tcol_in   = tcol_ff;
      cnt_in    = cnt_ff;
      kw_in     = kw_ff;
      dot_in    = dot_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      n         = 2'd0;
      redo      = 1'b0;
      flush     = 1'b0;
      idle_go   = 1'b0;
      fl        = 1'b0;
      for (int i = 0; i < MaxTokens; i++)
         desc[i] = '0;

      if (byte_present) begin
         unique case (mode_ff)
            M_COMMENT: if (is_nl) mode_in = M_IDLE;
            M_SLASH: begin
               if (b == 8'h2F) mode_in = M_COMMENT;
               else redo = 1'b1;
            end
            M_EQ, M_BANG, M_LT, M_GT: begin
               if (b == 8'h3D) begin
                  desc[n] = held(mode_ff == M_EQ ? K_EQ : mode_ff == M_BANG ? K_NEQ :
                                 mode_ff == M_LT ? K_LE : K_GE, 1'b0);
                  desc[n].len_sel = 2'd2;
                  n       = n + 2'd1;
                  mode_in = M_IDLE;
               end else begin
                  redo = 1'b1;
               end
            end
            M_INT: begin
               if (digit) cnt_in = cnt_inc;
               else if (b == 8'h2E) begin
                  mode_in = M_INTDOT;
                  dot_in  = col_ff;
               end else redo = 1'b1;
            end
            M_INTDOT: begin
               if (digit) begin
                  cnt_in  = (cnt_inc == LenMax) ? cnt_inc : cnt_inc + 1'b1;
                  mode_in = M_FLOAT;
               end else redo = 1'b1;
            end
            M_FLOAT: begin
               if (digit) cnt_in = cnt_inc;
               else redo = 1'b1;
            end
            M_WORD: begin
               if (digit || wstart) begin
                  for (int k = 0; k < NumKeywords; k++)
                     if ((cnt_ff >= LENGTH_BITS'(kw_len(3'(k)))) ||
                         (kw_byte(3'(k), kw_pos) != b))
                        kw_in[k] = 1'b0;
                  cnt_in = cnt_inc;
               end else redo = 1'b1;
            end
            default: idle_go = 1'b1;
         endcase
         if (redo) begin
            fl      = 1'b1;
            idle_go = 1'b1;
         end
         m = mode_ff;
      end

      // Flush the held token on a redo; end of source has its own decode below.
      if (fl) begin
         unique case (m)
            M_SLASH:  begin desc[n] = held(K_SLASH, 1'b0);   n = n + 2'd1; end
            M_EQ:     begin desc[n] = held(K_ASSIGN, 1'b0);  n = n + 2'd1; end
            M_BANG:   begin desc[n] = held(K_UNKNOWN, 1'b1); n = n + 2'd1; end
            M_LT:     begin desc[n] = held(K_LT, 1'b0);      n = n + 2'd1; end
            M_GT:     begin desc[n] = held(K_GT, 1'b0);      n = n + 2'd1; end
            M_INT:    begin desc[n] = held(K_INT, 1'b0);     n = n + 2'd1; end
            M_FLOAT:  begin desc[n] = held(K_FLOAT, 1'b0);   n = n + 2'd1; end
            M_WORD:   begin desc[n] = held(word_kind, 1'b0); n = n + 2'd1; end
            M_INTDOT: begin
               desc[n] = held(K_INT, 1'b0);
               n       = n + 2'd1;
               desc[n] = held(K_UNKNOWN, 1'b1);
               desc[n].dot_col = 1'b1;
               desc[n].len_sel = 2'd1;
               n       = n + 2'd1;
            end
            default: ;
         endcase
         mode_in = M_IDLE;
      end

      if (idle_go) begin
         mode_in = M_IDLE;
         unique case (b)
            8'h20, 8'h09, 8'h0D, 8'h0A: ;
            8'h2F, 8'h3D, 8'h21, 8'h3C, 8'h3E: begin
               mode_in  = (b == 8'h2F) ? M_SLASH : (b == 8'h3D) ? M_EQ :
                          (b == 8'h21) ? M_BANG : (b == 8'h3C) ? M_LT : M_GT;
               tline_in = line_ff;
               tcol_in  = col_ff;
               cnt_in   = LENGTH_BITS'(1);
            end
            8'h2B, 8'h2D, 8'h2A, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B: begin
               desc[n].kind = (b == 8'h2B) ? K_PLUS : (b == 8'h2D) ? K_MINUS :
                              (b == 8'h2A) ? K_STAR : (b == 8'h28) ? K_LPAREN :
                              (b == 8'h29) ? K_RPAREN : (b == 8'h7B) ? K_LBRACE :
                              (b == 8'h7D) ? K_RBRACE : K_SEMI;
               desc[n].at_cursor = 1'b1;
               desc[n].len_sel   = 2'd1;
               n = n + 2'd1;
            end
            default: begin
               if (digit || wstart) begin
                  mode_in  = digit ? M_INT : M_WORD;
                  tline_in = line_ff;
                  tcol_in  = col_ff;
                  cnt_in   = LENGTH_BITS'(1);
                  for (int k = 0; k < NumKeywords; k++)
                     kw_in[k] = (b == 8'hE0);
               end else begin
                  desc[n] = '{kind: K_UNKNOWN, err: 1'b1, at_cursor: 1'b1,
                              dot_col: 1'b0, len_sel: 2'd1};
                  n = n + 2'd1;
               end
            end
         endcase
      end

      if (byte_present) begin
         if (is_nl) begin
            line_in = (line_ff == LineMax) ? line_ff : line_ff + 1'b1;
            col_in  = COLUMN_BITS'(1);
         end else begin
            col_in = (col_ff == ColMax) ? col_ff : col_ff + 1'b1;
         end
      end
      flush = end_of_source;
   end

   // End of source acts on the state after the byte; that is a second scan
   // stage folded onto the same cycle, with its own small flush decode.
   tok_desc_type edesc [2];
   logic [1:0]   en;
   logic [4:0]   eword_kind;

   always_comb begin
      eword_kind = K_IDENT;
      for (int k = NumKeywords - 1; k >= 0; k--)
         if (kw_in[k] && (cnt_in == LENGTH_BITS'(kw_len(3'(k)))))
            eword_kind = 5'(k);
      edesc[0] = '0;
      edesc[1] = '0;
      en       = 2'd0;
      unique case (mode_in)
         M_SLASH:  begin edesc[0] = held(K_SLASH, 1'b0);   en = 2'd1; end
         M_EQ:     begin edesc[0] = held(K_ASSIGN, 1'b0);  en = 2'd1; end
         M_BANG:   begin edesc[0] = held(K_UNKNOWN, 1'b1); en = 2'd1; end
         M_LT:     begin edesc[0] = held(K_LT, 1'b0);      en = 2'd1; end
         M_GT:     begin edesc[0] = held(K_GT, 1'b0);      en = 2'd1; end
         M_INT:    begin edesc[0] = held(K_INT, 1'b0);     en = 2'd1; end
         M_FLOAT:  begin edesc[0] = held(K_FLOAT, 1'b0);   en = 2'd1; end
         M_WORD:   begin edesc[0] = held(eword_kind, 1'b0); en = 2'd1; end
         M_INTDOT: begin
            edesc[0] = held(K_INT, 1'b0);
            edesc[1] = held(K_UNKNOWN, 1'b1);
            edesc[1].dot_col = 1'b1;
            edesc[1].len_sel = 2'd1;
            en = 2'd2;
         end
         default: ;
      endcase
   end

   // Token assembly. Held tokens use the token registers as they stand
   // after the byte for the end flush, and before it for a redo flush.
   logic [2:0] total;
   always_comb begin
      tok_desc_type   d;
      logic [LINE_BITS-1:0]   ln;
      logic [COLUMN_BITS-1:0] cl;
      logic [LENGTH_BITS-1:0] lg;
      logic                   use_new;
      total = {1'b0, n};
      for (int i = 0; i < MaxTokens; i++) begin
         d       = desc[i];
         use_new = 1'b0;
         if (flush) begin
            if (i >= n && i < n + en) begin
               d       = edesc[1'(i - int'(n))];
               use_new = 1'b1;
            end else if (i == n + en) begin
               d = '{kind: K_EOF, err: 1'b0, at_cursor: 1'b1, dot_col: 1'b0,
                     len_sel: 2'd3};
               use_new = 1'b1;
            end
         end
         if (d.at_cursor) begin
            ln = line_ff;
            cl = col_ff;
            if (use_new) begin
               ln = line_in;
               cl = col_in;
            end
         end else begin
            ln = use_new ? tline_in : tline_ff;
            cl = use_new ? (d.dot_col ? dot_in : tcol_in) : (d.dot_col ? dot_ff : tcol_ff);
         end
         unique case (d.len_sel)
            2'd0:    lg = use_new ? cnt_in : cnt_ff;
            2'd1:    lg = LENGTH_BITS'(1);
            2'd2:    lg = LENGTH_BITS'(2);
            default: lg = '0;
         endcase
         tok_data[i] = {d.kind, ln, cl, lg, d.err, 1'b0};
      end
      if (flush)
         total = {1'b0, n} + {1'b0, en} + 3'd1;
      tok_count = total;
      if (total != 3'd0)
         tok_data[2'(total - 3'd1)][0] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         tline_ff <= LINE_BITS'(1);
         tcol_ff  <= COLUMN_BITS'(1);
         cnt_ff   <= '0;
         kw_ff    <= '0;
         line_ff  <= LINE_BITS'(1);
         col_ff   <= COLUMN_BITS'(1);
         dot_ff   <= COLUMN_BITS'(1);
      end else if (step) begin
         if (end_of_source) begin
            mode_ff  <= M_IDLE;
            tline_ff <= LINE_BITS'(1);
            tcol_ff  <= COLUMN_BITS'(1);
            cnt_ff   <= '0;
            kw_ff    <= '0;
            line_ff  <= LINE_BITS'(1);
            col_ff   <= COLUMN_BITS'(1);
            dot_ff   <= COLUMN_BITS'(1);
         end else begin
            mode_ff  <= mode_in;
            tline_ff <= tline_in;
            tcol_ff  <= tcol_in;
            cnt_ff   <= cnt_in;
            kw_ff    <= kw_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
            dot_ff   <= dot_in;
         end
      end
   end

endmodule : ukt_front
`default_nettype wire

// File: hw/rtl/ukt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukt_queue
// Token queue between the scanner and the output: takes up to four tokens a
// beat and hands out one token a beat.
// ----------------------------------------------------------------------------
module ukt_queue
   import ukt_pkg::*;
#(
   parameter int TOK_BITS = 5 + LineBitsDefault + ColumnBitsDefault + LengthBitsDefault + 2
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire logic [2:0]                         push_count,
   input  wire logic [MaxTokens-1:0][TOK_BITS-1:0] push_data,
   output logic                                    room,
   input  wire logic                               pop,
   output logic                                    out_valid,
   output logic [TOK_BITS-1:0]                     out_data
);

   localparam int Depth = 8;

   logic [TOK_BITS-1:0] mem_ff [Depth];
   logic [2:0] rd_ff, wr_ff;
   logic [3:0] fill_ff;
   logic [3:0] fill_in;

   // Room is judged on the fill after this beat's pop, so a full stream of
   // single tokens runs one per cycle while the receiver keeps popping.
   assign room      = ({1'b0, fill_ff} - {4'd0, pop} + 5'd4) <= 5'(Depth);
   assign out_valid = (fill_ff != 4'd0);
   assign out_data  = mem_ff[rd_ff];

   always_comb begin
      fill_in = fill_ff - {3'd0, pop} + (push ? {1'b0, push_count} : 4'd0);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < MaxTokens; i++)
            if (3'(i) < push_count)
               mem_ff[wr_ff + 3'(i)] <= push_data[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff   <= '0;
         wr_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (pop)  rd_ff <= rd_ff + 3'd1;
         if (push) wr_ff <= wr_ff + push_count;
         fill_ff <= fill_in;
      end
   end

endmodule : ukt_queue
`default_nettype wire

// File: hw/rtl/utf8_keyword_tokenizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_keyword_tokenizer_core
// Streaming lexer: one source byte per beat in, one token per beat out.
// ----------------------------------------------------------------------------
// Usage
// The req_ channel carries one source byte per beat, with byte_present and
// end_of_source flags. The scanner acts on each beat in the cycle it is
// accepted and writes the zero to four tokens it finishes into an eight-entry
// queue; the rsp_ channel drains that queue one token per beat, the final
// token of each request beat marked by rsp_last_of_run.
// The tokens of a request beat are registered in the queue before rsp_ shows them.
// Throughput is one request beat per cycle while the queue has room for four
// tokens; the queue read port gives one token per cycle while the receiver is
// ready, so the tokens of a beat that yields several leave one after another.
// When the receiver stalls, the queue fills and req_ready falls until the
// queue has room again; nothing is dropped.
// Reset clears the queue and returns the scanner to line 1, column 1 with no
// pending token. End of source returns the scanner to that state after its
// tokens are queued, but leaves the queue as it is.
module utf8_keyword_tokenizer_core
   import ukt_pkg::*;
#(
   parameter int LINE_BITS   = LineBitsDefault,
   parameter int COLUMN_BITS = ColumnBitsDefault,
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_source_byte,
   input  wire logic                   req_byte_present,
   input  wire logic                   req_end_of_source,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [4:0]                  rsp_token_kind,
   output logic [LINE_BITS-1:0]        rsp_start_line,
   output logic [COLUMN_BITS-1:0]      rsp_start_column,
   output logic [LENGTH_BITS-1:0]      rsp_token_length,
   output logic                        rsp_lexical_error,
   output logic                        rsp_last_of_run
);

   localparam int TokBits = 5 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 2;

   logic step, room;
   logic [2:0] tok_count;
   logic [MaxTokens-1:0][TokBits-1:0] tok_data;
   logic [TokBits-1:0] q_data;

   assign req_ready = room;
   assign step      = req_valid && room;

   ukt_front #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .TOK_BITS    (TokBits)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .source_byte   (req_source_byte),
      .byte_present  (req_byte_present),
      .end_of_source (req_end_of_source),
      .tok_count     (tok_count),
      .tok_data      (tok_data)
   );

   ukt_queue #(
      .TOK_BITS (TokBits)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (step),
      .push_count (tok_count),
      .push_data  (tok_data),
      .room       (room),
      .pop        (rsp_valid && rsp_ready),
      .out_valid  (rsp_valid),
      .out_data   (q_data)
   );

   assign {rsp_token_kind, rsp_start_line, rsp_start_column, rsp_token_length,
           rsp_lexical_error, rsp_last_of_run} = q_data;

endmodule : utf8_keyword_tokenizer_core
`default_nettype wire
